/* hw/rtl/wllrp_pkg.sv */
// Shared types and constants for the weighted least-loaded ring picker.
`timescale 1ns / 1ps

package wllrp_pkg;

    localparam int RING_COUNT = 4;
    localparam int LOAD_W     = 32;
    localparam int LEN_W      = 24;
    localparam int RING_ID_W  = 2;
    localparam int WIDE_W     = 4;
    localparam int SUM_W      = LOAD_W + 1;
    // Cost is sum doubled (SUM_W + 1) plus one pad bit so unused tree leaves never win.
    localparam int COST_W     = SUM_W + 2;

    localparam logic [WIDE_W-1:0] WIDE_RESET = WIDE_W'(3);

    typedef enum logic {
        CMD_ASSIGN  = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SATURATED = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                 cmd;
        logic [LEN_W-1:0]     length;
        logic [RING_ID_W-1:0] ring_index;
    } t_in_item;

    typedef struct packed {
        logic [RING_ID_W-1:0] chosen_ring;
        t_status              status;
    } t_out_item;

endpackage

/* hw/rtl/weighted_least_loaded_ring_picker.sv */
// Top level: weighted least-loaded ring picker with per-ring load counters.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_in_item  (cmd, length, ring_index)
// out      | output    | o_out_valid / i_out_ready  | o_out_item (chosen_ring, status)
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (ring_is_wide)
//
// Each transaction is captured in an input register, then the cost tree, load update
// and status are settled combinationally and land in the result register together with
// the new ring loads. One transaction per cycle is sustained while the result is not
// stalled, since the load update that the next pick depends on is combinational.
// Reset (synchronous, active low) clears all ring loads and sets ring_is_wide to 3.
// A stalled result holds the stage; the input register still takes a transaction when
// the result drains in the same cycle. The cfg port is always ready.

module weighted_least_loaded_ring_picker #(
    parameter int RING_COUNT = wllrp_pkg::RING_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  wllrp_pkg::t_in_item           i_in_item,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output wllrp_pkg::t_out_item          o_out_item,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wllrp_pkg::WIDE_W-1:0]  i_cfg_data
);

    localparam int RING_W = $clog2(RING_COUNT);
    // Pick index widened to at least the reported ring width before truncation.
    localparam int PICK_W = (RING_W < wllrp_pkg::RING_ID_W) ? wllrp_pkg::RING_ID_W : RING_W;
    localparam int LW     = wllrp_pkg::LOAD_W;
    localparam int SW     = wllrp_pkg::SUM_W;
    localparam int RIW    = wllrp_pkg::RING_ID_W;
    localparam int NAMED  = 1 << RIW;   // rings addressable by ring_index

    // Input stage
    logic                r_in_valid;
    wllrp_pkg::t_in_item r_in;

    // State and config
    logic [LW-1:0]                r_load [RING_COUNT];
    logic [LW-1:0]                n_load [RING_COUNT];
    logic [wllrp_pkg::WIDE_W-1:0] r_wide;

    // Result stage
    logic                 r_out_valid;
    wllrp_pkg::t_out_item r_out;
    wllrp_pkg::t_out_item n_out;

    logic              w_adv;
    logic [SW-1:0]     w_sum [RING_COUNT];
    logic [RING_W-1:0] w_pick;
    logic [PICK_W-1:0] w_pick_ext;
    logic [RING_COUNT-1:0] w_sat_sel;
    logic [RING_COUNT-1:0] w_und_sel;
    logic              w_assign;

    // Stage advances when the result register is free or being drained.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;
    assign w_assign   = (r_in.cmd == wllrp_pkg::CMD_ASSIGN);

    wllrp_pick #(
        .RING_COUNT (RING_COUNT)
    ) u_pick (
        .i_load   (r_load),
        .i_length (r_in.length),
        .i_wide   (r_wide),
        .o_sum    (w_sum),
        .o_pick   (w_pick)
    );

    // Per-ring next load: each counter only looks at its own hit flags.
    for (genvar i = 0; i < RING_COUNT; i++) begin : g_ring
        logic w_a_hit;
        logic w_r_hit;
        logic w_under;
        assign w_a_hit = w_assign && (w_pick == RING_W'(i));
        if (i < NAMED) begin : g_named
            assign w_r_hit = !w_assign && (r_in.ring_index == RIW'(i));
        end else begin : g_unnamed
            assign w_r_hit = 1'b0;
        end
        assign w_under      = LW'(r_in.length) > r_load[i];
        assign w_sat_sel[i] = w_a_hit && w_sum[i][SW-1];
        assign w_und_sel[i] = w_r_hit && w_under;

        always_comb begin
            if (w_a_hit) begin
                n_load[i] = w_sum[i][SW-1] ? {LW{1'b1}} : w_sum[i][LW-1:0];
            end else if (w_r_hit) begin
                n_load[i] = w_under ? '0 : r_load[i] - LW'(r_in.length);
            end else begin
                n_load[i] = r_load[i];
            end
        end
    end

    assign w_pick_ext = PICK_W'(w_pick);

    always_comb begin
        n_out.chosen_ring = w_assign ? w_pick_ext[RIW-1:0] : r_in.ring_index;
        if (|w_sat_sel) begin
            n_out.status = wllrp_pkg::ST_SATURATED;
        end else if (|w_und_sel) begin
            n_out.status = wllrp_pkg::ST_UNDERFLOW;
        end else begin
            n_out.status = wllrp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wide      <= wllrp_pkg::WIDE_RESET;
            for (int i = 0; i < RING_COUNT; i++) begin
                r_load[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < RING_COUNT; i++) begin
                    r_load[i] <= n_load[i];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_wide <= i_cfg_data;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* hw/rtl/wllrp_pick.sv */
// Per-ring cost formation and lowest-cost ring search (compare tree).
`timescale 1ns / 1ps

module wllrp_pick #(
    parameter int RING_COUNT = wllrp_pkg::RING_COUNT
) (
    input  logic [wllrp_pkg::LOAD_W-1:0] i_load [RING_COUNT],
    input  logic [wllrp_pkg::LEN_W-1:0]  i_length,
    input  logic [wllrp_pkg::WIDE_W-1:0] i_wide,
    output logic [wllrp_pkg::SUM_W-1:0]  o_sum  [RING_COUNT],
    output logic [$clog2(RING_COUNT)-1:0] o_pick
);

    localparam int RING_W = $clog2(RING_COUNT);
    localparam int NLEAF  = 1 << RING_W;
    localparam int NNODE  = 2 * NLEAF - 1;
    localparam int SW     = wllrp_pkg::SUM_W;
    localparam int CW     = wllrp_pkg::COST_W;

    logic [CW-1:0]     w_cost [NNODE];
    logic [RING_W-1:0] w_idx  [NNODE];

    // Leaves sit at NLEAF-1 .. 2*NLEAF-2 in heap order.
    for (genvar i = 0; i < NLEAF; i++) begin : g_leaf
        if (i < RING_COUNT) begin : g_ring
            logic w_is_wide;
            assign o_sum[i] = {1'b0, i_load[i]} + SW'(i_length);
            if (i < wllrp_pkg::WIDE_W) begin : g_cfg
                assign w_is_wide = i_wide[i];
            end else begin : g_narrow
                assign w_is_wide = 1'b0;
            end
            assign w_cost[NLEAF-1+i] = w_is_wide ? {2'b00, o_sum[i]}
                                                 : {1'b0, o_sum[i], 1'b0};
        end else begin : g_pad
            assign w_cost[NLEAF-1+i] = {1'b1, {(CW-1){1'b0}}};
        end
        assign w_idx[NLEAF-1+i] = RING_W'(i);
    end

    // Right child wins only when strictly cheaper, so ties keep the lower index.
    for (genvar k = 0; k < NLEAF - 1; k++) begin : g_node
        logic w_right;
        assign w_right   = w_cost[2*k+2] < w_cost[2*k+1];
        assign w_cost[k] = w_right ? w_cost[2*k+2] : w_cost[2*k+1];
        assign w_idx[k]  = w_right ? w_idx[2*k+2]  : w_idx[2*k+1];
    end

    assign o_pick = w_idx[0];

endmodule

/* dv/tb_weighted_least_loaded_ring_picker.sv */
// Self-checking testbench for the weighted least-loaded ring picker.
`timescale 1ns / 1ps

module tb_weighted_least_loaded_ring_picker;

    localparam int RING_COUNT = wllrp_pkg::RING_COUNT;
    localparam int LOAD_W     = wllrp_pkg::LOAD_W;
    localparam int LEN_W      = wllrp_pkg::LEN_W;
    localparam int RING_ID_W  = wllrp_pkg::RING_ID_W;
    localparam int WIDE_W     = wllrp_pkg::WIDE_W;

    // Result pipe is two deep; a little margin before touching ring_is_wide.
    localparam int SETTLE_CYCLES = 4;
    // Longest correct stretch with no transaction is far below this.
    localparam int STALL_LIMIT   = 1000;

    // One directed row: the transaction, and a hand-derived result where
    // it is obvious (pinned), otherwise the predictor decides.
    typedef struct packed {
        wllrp_pkg::t_in_item  item;
        logic                 pinned;
        wllrp_pkg::t_out_item want;
    } t_script_row;

    // Rows run with ring_is_wide at its reset value 3: rings 0/1 wide,
    // rings 2/3 narrow, all loads zero.
    localparam t_script_row SCRIPT [16] = '{
        // zero length: every cost is zero, tie goes to ring 0
        '{'{wllrp_pkg::CMD_ASSIGN,  24'h000000, 2'd0}, 1'b1, '{2'd0, wllrp_pkg::ST_OK}},
        // release max length from an empty ring clamps
        '{'{wllrp_pkg::CMD_RELEASE, 24'hFFFFFF, 2'd3}, 1'b1,
          '{2'd3, wllrp_pkg::ST_UNDERFLOW}},
        // zero-length release from an empty ring is fine
        '{'{wllrp_pkg::CMD_RELEASE, 24'h000000, 2'd2}, 1'b1, '{2'd2, wllrp_pkg::ST_OK}},
        // max length: wide rings tie, lowest index wins
        '{'{wllrp_pkg::CMD_ASSIGN,  24'hFFFFFF, 2'd3}, 1'b1, '{2'd0, wllrp_pkg::ST_OK}},
        // ring 0 now loaded, ring 1 is cheapest
        '{'{wllrp_pkg::CMD_ASSIGN,  24'hFFFFFF, 2'd0}, 1'b1, '{2'd1, wllrp_pkg::ST_OK}},
        // small lengths: narrow rings become cheaper than loaded wide ones
        '{'{wllrp_pkg::CMD_ASSIGN,  24'h000001, 2'd1}, 1'b0, '{2'd0, wllrp_pkg::ST_OK}},
        '{'{wllrp_pkg::CMD_ASSIGN,  24'h000001, 2'd2}, 1'b0, '{2'd0, wllrp_pkg::ST_OK}},
        '{'{wllrp_pkg::CMD_ASSIGN,  24'h800000, 2'd0}, 1'b0, '{2'd0, wllrp_pkg::ST_OK}},
        // release exactly the whole load: no clamp
        '{'{wllrp_pkg::CMD_RELEASE, 24'hFFFFFF, 2'd0}, 1'b1, '{2'd0, wllrp_pkg::ST_OK}},
        // one more element than the (now empty) load
        '{'{wllrp_pkg::CMD_RELEASE, 24'h000001, 2'd0}, 1'b1,
          '{2'd0, wllrp_pkg::ST_UNDERFLOW}},
        '{'{wllrp_pkg::CMD_RELEASE, 24'h000001, 2'd1}, 1'b0, '{2'd0, wllrp_pkg::ST_OK}},
        // one more element than the remaining load
        '{'{wllrp_pkg::CMD_RELEASE, 24'hFFFFFF, 2'd1}, 1'b1,
          '{2'd1, wllrp_pkg::ST_UNDERFLOW}},
        // alternating bit patterns on length
        '{'{wllrp_pkg::CMD_ASSIGN,  24'hAAAAAA, 2'd2}, 1'b0, '{2'd0, wllrp_pkg::ST_OK}},
        '{'{wllrp_pkg::CMD_ASSIGN,  24'h555555, 2'd1}, 1'b0, '{2'd0, wllrp_pkg::ST_OK}},
        '{'{wllrp_pkg::CMD_RELEASE, 24'h5A5A5A, 2'd3}, 1'b0, '{2'd0, wllrp_pkg::ST_OK}},
        '{'{wllrp_pkg::CMD_RELEASE, 24'h123456, 2'd2}, 1'b0, '{2'd0, wllrp_pkg::ST_OK}}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    wllrp_pkg::t_in_item  i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    wllrp_pkg::t_out_item o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [WIDE_W-1:0]    i_cfg_data;

    // Hand-derived result travels with the payload so that the monitor
    // sees it at the same edge as the transaction it belongs to.
    logic                 pinned_valid;
    wllrp_pkg::t_out_item pinned_result;

    // Shadow of the block: per-ring load and the wide-ring mask.
    logic [LOAD_W-1:0]    ring_load [RING_COUNT] = '{default: '0};
    logic [WIDE_W-1:0]    wide_rings = wllrp_pkg::WIDE_RESET;
    wllrp_pkg::t_out_item pending_picks [$];

    wllrp_pkg::t_out_item predicted;
    wllrp_pkg::t_out_item oldest;
    bit                   quiet = 1'b0;
    int unsigned          mismatches = 0;
    int unsigned          n_assign = 0;
    int unsigned          n_release = 0;
    int unsigned          n_saturated = 0;
    int unsigned          n_underflow = 0;
    int unsigned          n_mask_writes = 0;

    weighted_least_loaded_ring_picker #(
        .RING_COUNT (RING_COUNT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Pick a ring (or release load) on the shadow state and return the
    // result the block must report for this transaction.
    function automatic wllrp_pkg::t_out_item pick_and_update(input wllrp_pkg::t_in_item it);
        wllrp_pkg::t_out_item res;
        logic [LOAD_W:0]      sum;
        logic [LOAD_W+1:0]    cost;
        logic [LOAD_W+1:0]    best;
        int unsigned          pick;
        res.status = wllrp_pkg::ST_OK;
        pick = it.ring_index;
        if (it.cmd == wllrp_pkg::CMD_ASSIGN) begin
            // all-ones is above any real cost, so ring 0 always takes the first slot
            best = '1;
            for (int k = 0; k < RING_COUNT; k++) begin
                sum  = {1'b0, ring_load[k]} + (LOAD_W+1)'(it.length);
                // rings past the mask width count as narrow
                cost = (k < WIDE_W && wide_rings[k]) ? {1'b0, sum} : {sum, 1'b0};
                if (cost < best) begin
                    best = cost;
                    pick = k;
                end
            end
            sum = {1'b0, ring_load[pick]} + (LOAD_W+1)'(it.length);
            if (sum[LOAD_W]) begin
                ring_load[pick] = '1;
                res.status = wllrp_pkg::ST_SATURATED;
            end else begin
                ring_load[pick] = sum[LOAD_W-1:0];
            end
        end else if (pick < RING_COUNT) begin
            if (LOAD_W'(it.length) > ring_load[pick]) begin
                ring_load[pick] = '0;
                res.status = wllrp_pkg::ST_UNDERFLOW;
            end else begin
                ring_load[pick] = ring_load[pick] - LOAD_W'(it.length);
            end
        end
        res.chosen_ring = RING_ID_W'(pick);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Monitor: check results first, then queue the prediction, so that a
    // result can never be matched against a transaction of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                wide_rings = i_cfg_data;
                n_mask_writes++;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_picks.size() == 0) begin
                    $display("%0t ns: result with none expected, got ring %0d status %0d",
                             $time, o_out_item.chosen_ring, o_out_item.status);
                    mismatches++;
                end else begin
                    oldest = pending_picks.pop_front();
                    if (o_out_item.chosen_ring !== oldest.chosen_ring)
                        flag_mismatch("chosen_ring", oldest.chosen_ring, o_out_item.chosen_ring);
                    if (o_out_item.status !== oldest.status)
                        flag_mismatch("status", oldest.status, o_out_item.status);
                end
                if (o_out_item.status == wllrp_pkg::ST_SATURATED) n_saturated++;
                if (o_out_item.status == wllrp_pkg::ST_UNDERFLOW) n_underflow++;
            end
            if (i_in_valid && o_in_ready) begin
                predicted = pick_and_update(i_in_item);
                pending_picks.insert(pending_picks.size(),
                                     pinned_valid ? pinned_result : predicted);
                if (i_in_item.cmd == wllrp_pkg::CMD_ASSIGN) n_assign++;
                else n_release++;
            end
        end
    end

    // Result side: random stall bursts, none once the run goes quiet.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run if no transaction moves on any channel for too long.
    initial begin : watchdog
        int unsigned still_cycles;
        still_cycles = 0;
        while (still_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                still_cycles = 0;
            else
                still_cycles++;
        end
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Present one transaction, with an optional idle burst first; returns at
    // the edge where it is taken, leaving valid high for a back-to-back follow-up.
    task automatic offer_transaction(input wllrp_pkg::t_in_item it, input logic pin,
                                     input wllrp_pkg::t_out_item want);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_item     <= it;
        pinned_valid  <= pin;
        pinned_result <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop sending and wait until every expected result has drained.
    // The first edge lets the monitor queue the last accepted transaction.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring_mask(input logic [WIDE_W-1:0] mask);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mask;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mixed traffic keeps loads small so ties and clamped releases are common;
    // fill traffic is mostly near-max assigns that drive loads into saturation.
    function automatic wllrp_pkg::t_in_item make_traffic_item(input bit filling);
        wllrp_pkg::t_in_item it;
        it.ring_index = RING_ID_W'($urandom);
        if (filling) begin
            it.cmd = ($urandom_range(0, 99) < 94) ? wllrp_pkg::CMD_ASSIGN
                                                  : wllrp_pkg::CMD_RELEASE;
            if (it.cmd == wllrp_pkg::CMD_ASSIGN)
                it.length = LEN_W'($urandom_range(24'hF00000, 24'hFFFFFF));
            else
                it.length = LEN_W'($urandom);
        end else begin
            it.cmd = ($urandom_range(0, 99) < 60) ? wllrp_pkg::CMD_ASSIGN
                                                  : wllrp_pkg::CMD_RELEASE;
            case ($urandom_range(0, 3))
                0: it.length = LEN_W'($urandom_range(0, 15));
                1: it.length = LEN_W'($urandom);
                2: it.length = 24'hFFFFFF - LEN_W'($urandom_range(0, 3));
                default: it.length = LEN_W'($urandom & $urandom);
            endcase
        end
        return it;
    endfunction

    task automatic run_traffic(input int count, input bit filling, input int quiet_tail);
        for (int n = 0; n < count; n++) begin
            if (count - n <= quiet_tail) quiet = 1'b1;
            offer_transaction(make_traffic_item(filling), 1'b0, '0);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_item     <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        pinned_valid  <= 1'b0;
        pinned_result <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows against the reset mask
        foreach (SCRIPT[n])
            offer_transaction(SCRIPT[n].item, SCRIPT[n].pinned, SCRIPT[n].want);
        wait_drained();

        // all rings narrow
        write_ring_mask('0);
        run_traffic(170, 1'b0, 0);
        wait_drained();

        // all rings wide
        write_ring_mask('1);
        run_traffic(170, 1'b0, 0);
        wait_drained();

        // a random mix, with a full drain halfway through
        write_ring_mask(WIDE_W'($urandom_range(2, 14)));
        run_traffic(85, 1'b0, 0);
        wait_drained();
        run_traffic(85, 1'b0, 0);
        wait_drained();

        // only ring 0 wide: it carries the most load and is the first to
        // saturate; the tail of this phase runs with no idling at all
        write_ring_mask(WIDE_W'(1));
        run_traffic(900, 1'b1, 200);
        wait_drained();

        $display("Covered %0d assigns and %0d releases under %0d ring_is_wide settings,",
                 n_assign, n_release, n_mask_writes + 1);
        $display("including %0d saturated assigns and %0d clamped releases.",
                 n_saturated, n_underflow);
        if (mismatches == 0 && pending_picks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/wllrp_pkg.sv
hw/rtl/wllrp_pick.sv
hw/rtl/weighted_least_loaded_ring_picker.sv
dv/tb_weighted_least_loaded_ring_picker.sv
